// File: sv/pfaa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfaa_pkg
// Shared constants and types for the packed field array access block.
// ----------------------------------------------------------------------------
package pfaa_pkg;

  localparam int STORE_WORDS_DEF = 1024;
  localparam int WORD_BITS       = 64;
  localparam int OFF_W           = 6;
  localparam int WIDTH_W         = 7;
  localparam int COUNT_W         = 17;
  localparam int INDEX_W         = 16;
  localparam int POS_W           = INDEX_W + WIDTH_W;
  localparam int CFG_INDEX_W     = 1;

  localparam logic [WORD_BITS-1:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 17'd1024;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ELEMENT_WIDTH = 1'b0,
    REG_ELEMENT_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic {
    ACT_READ  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

endpackage

// File: sv/pfaa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfaa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pfaa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/packed_field_array_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_field_array_access
// Read and write of equal-width elements packed msb first into 64-bit words.
// ----------------------------------------------------------------------------
//  channel | direction | content
//  s_*     | in        | tuser: action; tdata: index [15:0], value [79:16]
//  m_*     | out       | tuser: ok; tdata: read_value [63:0]
//  cfg_*   | in        | cfg_index selects element_width or element_count
//
//  one word at a time, stepped by the single ram read port and write port:
//  multiply, range check, head read, tail read with head write-back, and
//  tail write-back for a straddling write; a refused word skips the ram.
//  sync reset restores element_width 8 and element_count 1024; ram is not
//  cleared. a stalled output holds the result; the next word is taken once
//  the result register has been loaded.
// ----------------------------------------------------------------------------
module packed_field_array_access
  import pfaa_pkg::*;
#(
  parameter int STORE_WORDS = STORE_WORDS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [79:0]            s_tdata,   // index, value
  input  logic                   s_tuser,   // action
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [63:0]            m_tdata,   // read_value
  output logic                   m_tuser,   // ok
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data
);

  localparam int AW         = $clog2(STORE_WORDS);
  localparam int STORE_BITS = STORE_WORDS * WORD_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CHECK, S_HEAD, S_TAIL, S_WTAIL, S_DONE
  } state_t;

  state_t                 state;
  logic [WIDTH_W-1:0]     element_width;
  logic [COUNT_W-1:0]     element_count;
  action_t                action;
  logic [INDEX_W-1:0]     index;
  logic [WORD_BITS-1:0]   value;
  logic [POS_W-1:0]       start;
  logic [AW-1:0]          head_addr;
  logic [AW-1:0]          tail_addr;
  logic [OFF_W-1:0]       off;
  logic [OFF_W-1:0]       lo;
  logic                   straddle;
  logic [WORD_BITS-1:0]   head_word;
  logic [WORD_BITS-1:0]   tail_new;
  logic [WORD_BITS-1:0]   result;
  logic                   ok;

  logic [WIDTH_W-1:0]     w_used;
  logic [WORD_BITS-1:0]   mask;
  logic [POS_W-1:0]       end_pos;
  logic [POS_W-1:0]       last_pos;
  logic                   refuse;
  logic [AW-1:0]          head_c;
  logic [AW-1:0]          tail_c;
  logic                   straddle_c;
  logic [WIDTH_W-1:0]     shift7;
  logic [WIDTH_W-1:0]     lo_comp;
  logic [WORD_BITS-1:0]   v_masked;
  logic [WORD_BITS-1:0]   hmask;
  logic [WORD_BITS-1:0]   rd_data;
  logic [WORD_BITS-1:0]   read_c;
  logic [WORD_BITS-1:0]   head_new_c;
  logic [WORD_BITS-1:0]   tail_new_c;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic                   out_free;

  always_comb begin
    if (element_width == '0) begin
      w_used = WIDTH_W'(1);
    end else if (element_width > WIDTH_W'(WORD_BITS)) begin
      w_used = WIDTH_W'(WORD_BITS);
    end else begin
      w_used = element_width;
    end
  end

  assign mask = w_used[WIDTH_W-1] ? ALL_ONES
              : (WORD_BITS'(1) << w_used[OFF_W-1:0]) - WORD_BITS'(1);

  assign end_pos    = start + POS_W'(w_used);
  assign last_pos   = end_pos - POS_W'(1);
  assign refuse     = ({1'b0, index} >= element_count) || (end_pos > POS_W'(STORE_BITS));
  assign head_c     = start[OFF_W +: AW];
  assign tail_c     = last_pos[OFF_W +: AW];
  assign straddle_c = start[POS_W-1:OFF_W] != last_pos[POS_W-1:OFF_W];

  assign shift7   = WIDTH_W'(WORD_BITS) - {1'b0, off} - w_used;
  assign lo_comp  = WIDTH_W'(WORD_BITS) - {1'b0, lo};
  assign v_masked = value & mask;
  assign hmask    = ALL_ONES >> off;

  always_comb begin
    if (straddle) begin
      read_c     = (((head_word & hmask) << lo) | (rd_data >> lo_comp)) & mask;
      head_new_c = (head_word & ~hmask) | (v_masked >> lo);
      tail_new_c = (rd_data & (ALL_ONES >> lo)) | (v_masked << lo_comp);
    end else begin
      read_c     = (head_word >> shift7[OFF_W-1:0]) & mask;
      head_new_c = (head_word & ~(mask << shift7[OFF_W-1:0]))
                 | (v_masked << shift7[OFF_W-1:0]);
      tail_new_c = rd_data;
    end
  end

  always_comb begin
    case (state)
      S_CHECK: ram_raddr = head_c;
      S_HEAD:  ram_raddr = tail_addr;
      default: ram_raddr = head_addr;
    endcase
  end

  always_comb begin
    case (state)
      S_TAIL: begin
        ram_we    = (action == ACT_WRITE);
        ram_waddr = head_addr;
        ram_wdata = head_new_c;
      end
      S_WTAIL: begin
        ram_we    = 1'b1;
        ram_waddr = tail_addr;
        ram_wdata = tail_new;
      end
      default: begin
        ram_we    = 1'b0;
        ram_waddr = head_addr;
        ram_wdata = head_new_c;
      end
    endcase
  end

  pfaa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      element_width <= WIDTH_RESET;
      element_count <= COUNT_RESET;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_ELEMENT_WIDTH: element_width <= cfg_data[WIDTH_W-1:0];
          REG_ELEMENT_COUNT: element_count <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            action <= action_t'(s_tuser);
            index  <= s_tdata[INDEX_W-1:0];
            value  <= s_tdata[79:INDEX_W];
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          start <= POS_W'({{WIDTH_W{1'b0}}, index} * {{INDEX_W{1'b0}}, w_used});
          state <= S_CHECK;
        end
        S_CHECK: begin
          head_addr <= head_c;
          tail_addr <= tail_c;
          off       <= start[OFF_W-1:0];
          lo        <= end_pos[OFF_W-1:0];
          straddle  <= straddle_c;
          result    <= '0;
          ok        <= !refuse;
          state     <= refuse ? S_DONE : S_HEAD;
        end
        S_HEAD: begin
          head_word <= rd_data;
          state     <= S_TAIL;
        end
        S_TAIL: begin
          tail_new <= tail_new_c;
          if (action == ACT_READ) begin
            result <= read_c;
          end
          state <= (action == ACT_WRITE && straddle) ? S_WTAIL : S_DONE;
        end
        S_WTAIL: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result;
            m_tuser  <= ok;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: tb/tb_packed_field_array_access.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_field_array_access
// Self-checking bench for the packed field array. A bit-level shadow of the
// word store predicts every read and every refusal. Directed words hit the
// width and count limits, straddling elements and the end of storage. Random
// write/read traffic follows under many register settings, with bursty input,
// output stalls and two long output hold-offs.
// ----------------------------------------------------------------------------
module tb_packed_field_array_access;
  import pfaa_pkg::*;

  typedef struct packed {
    logic [63:0] read_value;
    logic        ok;
  } answer_t;

  class packed_store_tracker;
    bit [63:0]         words [STORE_WORDS_DEF];
    bit [63:0]         known [STORE_WORDS_DEF];
    bit [WIDTH_W-1:0]  width_reg;
    bit [COUNT_W-1:0]  count_reg;
    answer_t           pending_answers [$];
    int                errors;

    function new();
      width_reg = WIDTH_RESET;
      count_reg = COUNT_RESET;
      errors    = 0;
    endfunction

    function void set_reg(reg_index_t r, logic [COUNT_W-1:0] d);
      if (r == REG_ELEMENT_WIDTH) width_reg = d[WIDTH_W-1:0];
      else count_reg = d;
    endfunction

    function int unsigned span();
      if (width_reg == 0) return 1;
      if (width_reg > WORD_BITS) return WORD_BITS;
      return width_reg;
    endfunction

    function bit fits(int unsigned idx);
      return (idx < count_reg) && ((idx + 1) * span() <= STORE_WORDS_DEF * WORD_BITS);
    endfunction

    // number of leading indexes that are accepted
    function int unsigned reach();
      int unsigned lim;
      int unsigned cap;
      lim = (count_reg > 65536) ? 65536 : count_reg;
      cap = (STORE_WORDS_DEF * WORD_BITS) / span();
      return (cap < lim) ? cap : lim;
    endfunction

    function bit readable(int unsigned idx);
      int unsigned pos;
      if (!fits(idx)) return 1'b1;
      for (int j = 0; j < span(); j++) begin
        pos = idx * span() + j;
        if (!known[pos / WORD_BITS][WORD_BITS - 1 - pos % WORD_BITS]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // element bit 0 of the store is the msb of word 0
    function void take_request(action_t act, logic [15:0] idx, logic [63:0] val);
      answer_t     a;
      int unsigned w;
      int unsigned pos;
      w = span();
      a.read_value = '0;
      a.ok = 1'b0;
      if (fits(idx)) begin
        a.ok = 1'b1;
        for (int j = 0; j < w; j++) begin
          pos = idx * w + j;
          if (act == ACT_READ) begin
            a.read_value = {a.read_value[62:0],
                            words[pos / WORD_BITS][WORD_BITS - 1 - pos % WORD_BITS]};
          end else begin
            words[pos / WORD_BITS][WORD_BITS - 1 - pos % WORD_BITS] = val[w - 1 - j];
            known[pos / WORD_BITS][WORD_BITS - 1 - pos % WORD_BITS] = 1'b1;
          end
        end
      end
      pending_answers.push_back(a);
    endfunction

    function void match_answer(logic [63:0] rv, logic ok);
      answer_t a;
      if (pending_answers.size() == 0) begin
        $error("result word with nothing expected: read_value %h ok %b", rv, ok);
        errors++;
        return;
      end
      a = pending_answers.pop_front();
      if (rv !== a.read_value) begin
        $error("read_value mismatch: expected %h, actual %h", a.read_value, rv);
        errors++;
      end
      if (ok !== a.ok) begin
        $error("ok mismatch: expected %b, actual %b", a.ok, ok);
        errors++;
      end
    endfunction
  endclass

  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 3000;
  localparam int ITEM_TARGET = 1150;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [79:0]            s_tdata   = '0;   // index [15:0], value [79:16]
  logic                   s_tuser   = 1'b0; // action
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [63:0]            m_tdata;          // read_value
  logic                   m_tuser;          // ok
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_ELEMENT_WIDTH;
  logic [COUNT_W-1:0]     cfg_data  = '0;

  packed_store_tracker book = new();

  int          sent        = 0;
  int          burst_left  = 0;
  bit          tx_gaps_on  = 1'b1;
  bit          rx_stall_on = 1'b1;
  int          hold_asks   = 0;
  int          hold_seen   = 0;
  int          hold_left   = 0;
  bit [7:0]    stall_pat   = 8'b1011_0111;
  int          pat_pos     = 0;
  int          idle_cycles = 0;
  int unsigned win_base    = 0;
  int unsigned recent [$];

  packed_field_array_access u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: own stall pattern plus an on-demand long hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.match_answer(m_tdata, m_tuser);
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_stall_on) begin
      m_tready <= stall_pat[pat_pos];
      pat_pos = pat_pos + 1;
      if (pat_pos == 8) begin
        pat_pos = 0;
        stall_pat = 8'($urandom) | 8'h01;
      end
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("packed_field_array_access verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input action_t act, input logic [15:0] idx, input logic [63:0] val);
    if (tx_gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, idx};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    book.take_request(act, idx, val);
    sent++;
    if (burst_left > 0) burst_left--;
  endtask

  task automatic write_reg(input reg_index_t r, input logic [COUNT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    book.set_reg(r, d);
  endtask

  task automatic set_phase(input logic [WIDTH_W-1:0] w, input logic [COUNT_W-1:0] c);
    int unsigned lim;
    s_tvalid <= 1'b0;
    while (book.pending_answers.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    write_reg(REG_ELEMENT_WIDTH, COUNT_W'(w));
    write_reg(REG_ELEMENT_COUNT, c);
    cfg_valid <= 1'b0;
    recent.delete();
    lim = book.reach();
    win_base = (lim > 48) ? $urandom_range(0, lim - 48) : 0;
    tx_gaps_on  = ($urandom_range(0, 3) != 0);
    rx_stall_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic random_items(input int n);
    int unsigned lim;
    int unsigned idx;
    int unsigned roll;
    logic [63:0] v;
    action_t     act;
    repeat (n) begin
      lim  = book.reach();
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0: v = ALL_ONES;
        1: v = '0;
        default: v = {$urandom, $urandom};
      endcase
      if (lim < 65536 && (roll < 6 || lim == 0)) begin
        idx = $urandom_range(lim, 65535);
        act = action_t'($urandom_range(0, 1));
      end else begin
        if (roll < 40 && recent.size() != 0) begin
          idx = recent[$urandom_range(0, recent.size() - 1)];
        end else if (roll < 75) begin
          idx = win_base + $urandom_range(0, 47);
          if (idx >= lim) idx = lim - 1;
        end else begin
          idx = $urandom_range(0, lim - 1);
        end
        act = (book.readable(idx) && $urandom_range(0, 2) != 0) ? ACT_READ : ACT_WRITE;
        if (act == ACT_WRITE) begin
          recent.push_back(idx);
          if (recent.size() > 64) void'(recent.pop_front());
        end
      end
      send_item(act, idx[15:0], v);
    end
  endtask

  initial begin
    logic [WIDTH_W-1:0] widths [10] = '{7'd0, 7'd127, 7'd7, 7'd33, 7'd63,
                                        7'd5, 7'd40, 7'd1, 7'd64, 7'd17};
    logic [COUNT_W-1:0] counts [10] = '{17'd100, 17'd600, 17'd1, 17'd0, 17'd2000,
                                        17'd17, 17'd70000, 17'd65536, 17'd1024, 17'd3000};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 8-bit elements, 1024 of them
    send_item(ACT_WRITE, 16'd0, ALL_ONES);
    send_item(ACT_READ, 16'd0, {$urandom, $urandom});
    send_item(ACT_WRITE, 16'd1023, 64'h1234_5678_9abc_de5a);
    send_item(ACT_READ, 16'd1023, '0);
    send_item(ACT_WRITE, 16'd1024, ALL_ONES);
    send_item(ACT_READ, 16'd1024, '0);
    send_item(ACT_READ, 16'd65535, ALL_ONES);
    send_item(ACT_WRITE, 16'd1, '0);
    send_item(ACT_READ, 16'd1, '0);
    send_item(ACT_READ, 16'd0, '0);
    random_items(40);
    hold_asks++;
    random_items(40);

    // straddling elements and the end of storage
    set_phase(7'd13, 17'd65536);
    send_item(ACT_WRITE, 16'd4, ALL_ONES);
    send_item(ACT_WRITE, 16'd3, '0);
    send_item(ACT_WRITE, 16'd5, '0);
    send_item(ACT_READ, 16'd4, '0);
    send_item(ACT_READ, 16'd3, ALL_ONES);
    send_item(ACT_WRITE, 16'd5040, 64'h0000_0000_0000_1abc);
    send_item(ACT_READ, 16'd5040, '0);
    send_item(ACT_WRITE, 16'd5041, ALL_ONES);
    send_item(ACT_READ, 16'd65535, '0);
    random_items(60);

    set_phase(7'd64, 17'd131071);
    send_item(ACT_WRITE, 16'd1023, ALL_ONES);
    send_item(ACT_READ, 16'd1023, '0);
    send_item(ACT_WRITE, 16'd1024, ALL_ONES);
    random_items(60);

    set_phase(7'd1, 17'd131071);
    send_item(ACT_WRITE, 16'd65535, ALL_ONES);
    send_item(ACT_READ, 16'd65535, '0);
    random_items(60);

    foreach (widths[i]) begin
      set_phase(widths[i], counts[i]);
      if (i == 4) hold_asks++;
      random_items(60);
    end

    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) set_phase(7'($urandom_range(0, 127)),
                                               17'($urandom_range(0, 131071)));
      else set_phase(7'($urandom_range(1, 64)), 17'($urandom_range(1, 70000)));
      random_items(50);
    end

    s_tvalid <= 1'b0;
    while (book.pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("packed_field_array_access verification clean");
    end else begin
      $display("packed_field_array_access verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/pfaa_pkg.sv
sv/pfaa_ram.sv
sv/packed_field_array_access.sv
tb/tb_packed_field_array_access.sv
